@@ rtl/cpi_pkg.sv @@
// ----------------------------------------------------------------------------
// cpi_pkg: shared definitions for the convex polygon point-inside unit
// Default sizes, input mode codes, the sequencer state type and the control
// word that the sequencer sends to the cross product unit.
// ----------------------------------------------------------------------------
package cpi_pkg;

   // Default capacity of the vertex store and coordinate width.
   localparam int CPI_MAX_VERTICES = 16;
   localparam int CPI_COORD_BITS   = 16;

   // Width of the vertex count register and of the vertex index field.
   localparam int CPI_VCOUNT_W = 5;
   localparam int CPI_VINDEX_W = 4;

   // Input word modes.
   localparam logic CPI_MODE_LOAD  = 1'b0;
   localparam logic CPI_MODE_QUERY = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_MUL_A,
      S_MUL_B,
      S_DRAIN,
      S_DONE
   } cpi_state_type;

   // Control word for the shared cross product unit.
   typedef struct packed {
      logic clear;   // start of a query: drop any earlier failure
      logic en;      // run the multiplier this cycle
      logic sel_b;   // second product of the edge, (py-sy)*(ex-sx)
   } cpi_mul_ctl_type;

endpackage

@@ rtl/cpi_vertex_ram.sv @@
// ----------------------------------------------------------------------------
// cpi_vertex_ram: vertex store
// One write port and one read port with registered read data. Each entry
// holds the x coordinate in the upper half and the y coordinate below it.
// ----------------------------------------------------------------------------
module cpi_vertex_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cpi_cross_unit.sv @@
// ----------------------------------------------------------------------------
// cpi_cross_unit: shared edge side test
// One signed multiplier forms the two products of an edge in turn; the
// following cycle compares them and records any edge the point is left of.
// ----------------------------------------------------------------------------
module cpi_cross_unit
   import cpi_pkg::*;
#(
   parameter int COORD_BITS = CPI_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cpi_mul_ctl_type              ctl,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] sx,
   input  logic signed [COORD_BITS-1:0] sy,
   input  logic signed [COORD_BITS-1:0] ex,
   input  logic signed [COORD_BITS-1:0] ey,
   output logic                         fail
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] m1;
   logic signed [DW-1:0] m2;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] lhs_ff;
   logic                 pair_ff;
   logic                 pair_in;
   logic                 fail_ff;
   logic                 fail_in;

   // Differences are one bit wider than the coordinates, so they never wrap.
   always_comb begin
      if (ctl.sel_b) begin
         m1 = DW'(py) - DW'(sy);
         m2 = DW'(ex) - DW'(sx);
      end else begin
         m1 = DW'(px) - DW'(sx);
         m2 = DW'(ey) - DW'(sy);
      end
      prod_in = m1 * m2;
   end

   assign pair_in = ctl.en & ctl.sel_b & ~ctl.clear;

   always_comb begin
      if (ctl.clear) begin
         fail_in = 1'b0;
      end else if (pair_ff && (lhs_ff < prod_ff)) begin
         fail_in = 1'b1;
      end else begin
         fail_in = fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         prod_ff <= prod_in;
      end
      if (ctl.en && ctl.sel_b) begin
         lhs_ff <= prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= 1'b0;
         fail_ff <= 1'b0;
      end else begin
         pair_ff <= pair_in;
         fail_ff <= fail_in;
      end
   end

   assign fail = fail_ff;

endmodule

@@ rtl/convex_polygon_point_inside_unit.sv @@
// ----------------------------------------------------------------------------
// convex_polygon_point_inside_unit: point in convex polygon test
// Stores polygon vertices and answers whether a query point lies right of or
// on every edge, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one vertex into the slot given by its index;
// it produces no result, and a slot at or above the store capacity is
// ignored. A query word (mode 1) walks the edges from vertex i to
// vertex i+1 for i from 0 to count-2, where count is the vertex count
// register limited to the store capacity; there is no closing edge, so the
// caller repeats the first vertex at the end of the list. For every edge the
// unit forms the exact cross product (px-sx)*(ey-sy) - (py-sy)*(ex-sx), and
// the point is reported inside only if no edge gives a negative value, so
// boundary points count as inside. With fewer than two vertices the answer is
// inside. A query holds the input stalled after it is accepted while the
// single multiplier works through the sequencer: a fetch state loads the
// first vertex, the two products of each of the count-1 edges are formed in
// turn, a drain state compares the last pair of products and a done state
// hands the answer to the output register; below two vertices only the done
// state runs. If the previous answer is still stalled in that register, the
// hand-over waits and the input stays stalled longer. The result waits in an
// output register; the next word may be accepted while it waits. Every vertex
// a query reads must have been loaded since reset. The user must write the
// vertex count through the csr port only while the unit is idle; the unit itself does not enforce it.
module convex_polygon_point_inside_unit
   import cpi_pkg::*;
#(
   parameter int MAX_VERTICES = CPI_MAX_VERTICES,
   parameter int COORD_BITS   = CPI_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration: vertex count.
   input  logic                         csr_write_en,
   input  logic [CPI_VCOUNT_W-1:0]      csr_write_data,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [CPI_VINDEX_W-1:0]      req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_inside_res
);

   // Address width of the store, and a width that holds the capacity itself.
   localparam int IDX_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W  = (CNT_W > CPI_VCOUNT_W) ? CNT_W : CPI_VCOUNT_W;
   localparam int IXW    = (CNT_W > CPI_VINDEX_W) ? CNT_W : CPI_VINDEX_W;
   localparam int WORD_W = 2 * COORD_BITS;

   cpi_state_type state_ff;
   cpi_state_type state_in;

   logic [CPI_VCOUNT_W-1:0]      vertex_count_ff;
   logic signed [COORD_BITS-1:0] px_ff;
   logic signed [COORD_BITS-1:0] py_ff;
   logic signed [COORD_BITS-1:0] sx_ff;
   logic signed [COORD_BITS-1:0] sy_ff;
   logic [IDX_W-1:0]             end_idx_ff;
   logic [IDX_W-1:0]             end_idx_in;
   logic [IDX_W-1:0]             last_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_inside_ff;

   logic                    req_take;
   logic                    query_take;
   logic [CMP_W-1:0]        count_ext;
   logic [CMP_W-1:0]        n_ext;
   logic [CMP_W-1:0]        n_m1;
   logic                    few_vertices;
   logic [IXW-1:0]          idx_ext;
   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [WORD_W-1:0]       rd_data;
   logic                    start_load;
   logic                    rsp_load;
   logic                    out_free;
   logic                    fail;
   cpi_mul_ctl_type         mul_ctl;

   assign req_take   = req_valid & ~req_stall;
   assign query_take = req_take & (req_mode == CPI_MODE_QUERY);
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Number of vertices in use, limited to the store capacity.
   assign count_ext    = CMP_W'(vertex_count_ff);
   assign n_ext        = (count_ext > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES)
                                                            : count_ext;
   assign n_m1         = n_ext - CMP_W'(1);
   assign few_vertices = n_ext < CMP_W'(2);

   // A load to a slot beyond the capacity is dropped.
   assign idx_ext = IXW'(req_vertex_index);
   assign wr_en   = req_take & (req_mode == CPI_MODE_LOAD)
                  & (idx_ext < IXW'(MAX_VERTICES));

   cpi_vertex_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (WORD_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[IDX_W-1:0]),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpi_cross_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .px    (px_ff),
      .py    (py_ff),
      .sx    (sx_ff),
      .sy    (sy_ff),
      .ex    (rd_data[WORD_W-1:COORD_BITS]),
      .ey    (rd_data[COORD_BITS-1:0]),
      .fail  (fail)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (query_take) begin
               state_in = few_vertices ? S_DONE : S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            state_in = (end_idx_ff == last_ff) ? S_DRAIN : S_MUL_A;
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs. The read address leads the registered read data:
   // while an edge finishes, the end vertex of the next edge is fetched.
   always_comb begin
      req_stall   = 1'b1;
      rd_addr     = end_idx_ff;
      start_load  = 1'b0;
      rsp_load    = 1'b0;
      mul_ctl     = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall     = 1'b0;
            rd_addr       = '0;
            mul_ctl.clear = query_take;
         end
         S_FETCH: begin
            start_load = 1'b1;
         end
         S_MUL_A: begin
            mul_ctl.en = 1'b1;
         end
         S_MUL_B: begin
            mul_ctl.en    = 1'b1;
            mul_ctl.sel_b = 1'b1;
            rd_addr       = end_idx_ff + IDX_W'(1);
            start_load    = 1'b1;
         end
         S_DRAIN: begin
            rsp_load = 1'b0;
         end
         S_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      end_idx_in = end_idx_ff;
      if (query_take) begin
         end_idx_in = IDX_W'(1);
      end else if (state_ff == S_MUL_B) begin
         end_idx_in = end_idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vertex_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            vertex_count_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      end_idx_ff <= end_idx_in;
      if (query_take) begin
         px_ff   <= req_coord_x;
         py_ff   <= req_coord_y;
         last_ff <= n_m1[IDX_W-1:0];
      end
      if (start_load) begin
         sx_ff <= rd_data[WORD_W-1:COORD_BITS];
         sy_ff <= rd_data[COORD_BITS-1:0];
      end
      if (rsp_load) begin
         rsp_inside_ff <= ~fail;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

`ifndef ASSERT_OFF
   // The edge walk never reads past the last vertex in use.
   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_A || state_ff == S_MUL_B) |-> (end_idx_ff <= last_ff))
      else $error("edge end index beyond last vertex");

   // Both products of an edge are formed on consecutive cycles.
   a_mul_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_B) |-> ($past(state_ff) == S_MUL_A))
      else $error("second product without first");

   // A query with no edges goes straight to its answer.
   a_no_edges: assert property (@(posedge clock) disable iff (reset)
      (query_take && few_vertices) |=> (state_ff == S_DONE && !fail))
      else $error("query without edges did not finish at once");

   // A new response appears only when a query finishes.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the finishing state");
`endif

endmodule
